FILE: rtl/skyline_rect_allocator_defines.svh
`ifndef SKYLINE_RECT_ALLOCATOR_DEFINES_SVH
`define SKYLINE_RECT_ALLOCATOR_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define SRA_AST_HOLD(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define SRA_AST_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/sra_pkg.sv
`timescale 1ns / 1ps

package sra_pkg;

    // Microprogram addresses.
    typedef enum logic [3:0] {
        U_BOOT      = 4'd0,
        U_IDLE      = 4'd1,
        U_DISP_CLR  = 4'd2,
        U_DISP_ZERO = 4'd3,
        U_DISP_WIDE = 4'd4,
        U_PASS1     = 4'd5,
        U_TURN      = 4'd6,
        U_PASS2     = 4'd7,
        U_DRAIN     = 4'd8,
        U_DECIDE    = 4'd9,
        U_RAISE     = 4'd10,
        U_RESULT    = 4'd11,
        U_LOOP      = 4'd12,
        U_ZERO      = 4'd13,
        U_CLEAR     = 4'd14,
        U_CLR_END   = 4'd15
    } t_upc;

    // Column counter operations.
    typedef enum logic [2:0] {
        CNT_HOLD,
        CNT_ZERO,
        CNT_TOP,
        CNT_UP,
        CNT_DOWN,
        CNT_BX
    } t_cnt_op;

    // Datapath actions.
    typedef enum logic [3:0] {
        A_NONE,
        A_CLEAR,
        A_TAKE,
        A_SCAN_UP,
        A_SCAN_DOWN,
        A_DECIDE,
        A_RAISE,
        A_RESULT,
        A_ZERO
    } t_act;

    // Jump conditions.
    typedef enum logic [3:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_ITEM,
        C_IS_CLEAR,
        C_W_ZERO,
        C_TOO_WIDE,
        C_NOT_LAST,
        C_NOT_ZERO,
        C_NO_WRITE,
        C_NOT_END,
        C_OUT_BUSY
    } t_cond;

    // One control word: counter op, action, jump condition and jump target.
    typedef struct packed {
        t_cnt_op cnt_op;
        t_act    act;
        t_cond   cond;
        t_upc    target;
    } t_uword;

    // Flags from the datapath that the jump conditions test.
    typedef struct packed {
        logic accept;
        logic is_clear;
        logic w_zero;
        logic too_wide;
        logic cnt_last;
        logic cnt_zero;
        logic no_write;
        logic cnt_end;
        logic out_busy;
    } t_status;

    // Control store. A step falls through to the next address unless its
    // condition holds, in which case it jumps to its target.
    function automatic t_uword sra_rom(input t_upc pc);
        t_uword uw;
        unique case (pc)
            U_BOOT:      uw = '{CNT_UP,   A_CLEAR,     C_NOT_LAST, U_BOOT};
            U_IDLE:      uw = '{CNT_ZERO, A_TAKE,      C_NO_ITEM,  U_IDLE};
            U_DISP_CLR:  uw = '{CNT_HOLD, A_NONE,      C_IS_CLEAR, U_CLEAR};
            U_DISP_ZERO: uw = '{CNT_HOLD, A_NONE,      C_W_ZERO,   U_ZERO};
            U_DISP_WIDE: uw = '{CNT_HOLD, A_NONE,      C_TOO_WIDE, U_RESULT};
            U_PASS1:     uw = '{CNT_UP,   A_SCAN_UP,   C_NOT_LAST, U_PASS1};
            U_TURN:      uw = '{CNT_TOP,  A_NONE,      C_NEVER,    U_IDLE};
            U_PASS2:     uw = '{CNT_DOWN, A_SCAN_DOWN, C_NOT_ZERO, U_PASS2};
            U_DRAIN:     uw = '{CNT_HOLD, A_NONE,      C_NEVER,    U_IDLE};
            U_DECIDE:    uw = '{CNT_BX,   A_DECIDE,    C_NO_WRITE, U_RESULT};
            U_RAISE:     uw = '{CNT_UP,   A_RAISE,     C_NOT_END,  U_RAISE};
            U_RESULT:    uw = '{CNT_HOLD, A_RESULT,    C_OUT_BUSY, U_RESULT};
            U_LOOP:      uw = '{CNT_HOLD, A_NONE,      C_ALWAYS,   U_IDLE};
            U_ZERO:      uw = '{CNT_HOLD, A_ZERO,      C_ALWAYS,   U_DECIDE};
            U_CLEAR:     uw = '{CNT_UP,   A_CLEAR,     C_NOT_LAST, U_CLEAR};
            U_CLR_END:   uw = '{CNT_HOLD, A_NONE,      C_ALWAYS,   U_RESULT};
            default:     uw = '{CNT_HOLD, A_NONE,      C_ALWAYS,   U_IDLE};
        endcase
        return uw;
    endfunction

endpackage

FILE: rtl/skyline_rect_allocator.sv
`timescale 1ns / 1ps

// Channel  Direction  Valid        Stall        Payload
// in       input      i_in_valid   o_in_stall   i_kind, i_rect_width, i_rect_height
// out      output     o_out_valid  i_out_stall  o_granted, o_pos_x, o_pos_y
//
// An allocate beat runs forward and backward sweeps of the column memory, one read per cycle,
// and when granted then raises the columns of its span. A zero-width beat, a beat at least
// SHEET_WIDTH wide and a clear skip the sweeps; a clear rewrites every column to zero.
// After reset a clearing pass over every column runs before the first beat is taken.
// The result waits in an output register while the next beat is taken; the block holds in its
// result step only while an earlier result is still stalled in that register.

module skyline_rect_allocator
    import sra_pkg::*;
#(
    parameter int SHEET_WIDTH  = 128,
    parameter int SHEET_HEIGHT = 128
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic       i_kind,
    input  logic [7:0] i_rect_width,
    input  logic [7:0] i_rect_height,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic       o_granted,
    output logic [6:0] o_pos_x,
    output logic [7:0] o_pos_y
);

    t_uword  uword;
    t_status status;

    // Microprogram sequencer.
    sra_useq u_useq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_status(status),
        .o_uword (uword)
    );

    // Column store, scan datapath and output register.
    sra_dpath #(
        .SHEET_WIDTH (SHEET_WIDTH),
        .SHEET_HEIGHT(SHEET_HEIGHT)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_uword      (uword),
        .o_status     (status),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_kind       (i_kind),
        .i_rect_width (i_rect_width),
        .i_rect_height(i_rect_height),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_granted    (o_granted),
        .o_pos_x      (o_pos_x),
        .o_pos_y      (o_pos_y)
    );

endmodule

FILE: rtl/sra_ram.sv
`timescale 1ns / 1ps

module sra_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/sra_useq.sv
`timescale 1ns / 1ps

`include "skyline_rect_allocator_defines.svh"

module sra_useq
    import sra_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_status i_status,
    output t_uword  o_uword
);

    t_upc   r_pc;
    t_upc   n_pc;
    t_uword uw;
    logic   jump;

    // Step counter; reset starts the clearing pass.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= U_BOOT;
        end else begin
            r_pc <= n_pc;
        end
    end

    // Fetch the control word and resolve the jump condition.
    always_comb begin
        uw = sra_rom(r_pc);
        unique case (uw.cond)
            C_NEVER:    jump = 1'b0;
            C_ALWAYS:   jump = 1'b1;
            C_NO_ITEM:  jump = !i_status.accept;
            C_IS_CLEAR: jump = i_status.is_clear;
            C_W_ZERO:   jump = i_status.w_zero;
            C_TOO_WIDE: jump = i_status.too_wide;
            C_NOT_LAST: jump = !i_status.cnt_last;
            C_NOT_ZERO: jump = !i_status.cnt_zero;
            C_NO_WRITE: jump = i_status.no_write;
            C_NOT_END:  jump = !i_status.cnt_end;
            C_OUT_BUSY: jump = i_status.out_busy;
            default:    jump = 1'b0;
        endcase
        n_pc = jump ? uw.target : t_upc'(r_pc + 4'd1);
    end

    assign o_uword = uw;

    `SRA_AST_NEXT(a_take_dispatch, i_clk, i_rst_n, i_status.accept, r_pc == U_DISP_CLR, "accepted beat did not reach dispatch")
    `SRA_AST_NEXT(a_result_leaves, i_clk, i_rst_n, (r_pc == U_RESULT) && !i_status.out_busy, r_pc == U_LOOP, "result step did not finish")
    `SRA_AST_NEXT(a_pass1_exit, i_clk, i_rst_n, r_pc == U_PASS1, (r_pc == U_PASS1) || (r_pc == U_TURN), "first pass left its loop early")

endmodule

FILE: rtl/sra_dpath.sv
`timescale 1ns / 1ps

`include "skyline_rect_allocator_defines.svh"

module sra_dpath
    import sra_pkg::*;
#(
    parameter int SHEET_WIDTH  = 128,
    parameter int SHEET_HEIGHT = 128
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_uword     i_uword,
    output t_status    o_status,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic       i_kind,
    input  logic [7:0] i_rect_width,
    input  logic [7:0] i_rect_height,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic       o_granted,
    output logic [6:0] o_pos_x,
    output logic [7:0] o_pos_y
);

    localparam int AW = $clog2(SHEET_WIDTH);
    localparam int HW = $clog2(SHEET_HEIGHT + 1);
    localparam int SW = ((AW > 8) ? AW : 8) + 1;
    localparam int FW = ((HW > 8) ? HW : 8) + 1;

    // Control registers.
    logic [AW-1:0] r_cnt;
    logic [AW-1:0] n_cnt;
    logic [7:0]    r_k;
    logic          r_found;
    logic          r_up_vld;
    logic          r_dn_vld;
    logic          r_out_valid;

    // Payload registers.
    logic          r_kind;
    logic [7:0]    r_w;
    logic [7:0]    r_h;
    logic [HW-1:0] r_pre;
    logic [HW-1:0] r_suf;
    logic [HW-1:0] r_best;
    logic [AW-1:0] r_bx;
    logic [AW-1:0] r_end;
    logic [AW-1:0] r_idx;
    logic          r_inrange;
    logic          r_granted;
    logic [6:0]    r_pos_x;
    logic [7:0]    r_pos_y;

    // Memory ports.
    logic          col_we;
    logic [HW-1:0] col_wdata;
    logic [HW-1:0] col_rdata;
    logic [AW-1:0] pre_raddr;
    logic [HW-1:0] pre_rdata;

    // Datapath terms.
    logic          accept;
    logic          take;
    logic          out_busy;
    logic          res_load;
    logic [SW-1:0] w_ext;
    logic [SW-1:0] span_end;
    logic          inrange_now;
    logic [FW-1:0] raise_sum;
    logic          fit;
    logic          granted;
    logic [SW-1:0] bx_ext;
    logic [FW-1:0] best_ext;
    logic [HW-1:0] up_pre;
    logic [7:0]    k_inc;
    logic [7:0]    k_dec;
    logic [HW-1:0] dn_suf;
    logic [HW-1:0] span_top;
    logic          better;

    // Column heights and per-block prefix maxima.
    sra_ram #(
        .WIDTH(HW),
        .DEPTH(SHEET_WIDTH)
    ) u_col_ram (
        .i_clk  (i_clk),
        .i_we   (col_we),
        .i_waddr(r_cnt),
        .i_wdata(col_wdata),
        .i_raddr(r_cnt),
        .o_rdata(col_rdata)
    );

    sra_ram #(
        .WIDTH(HW),
        .DEPTH(SHEET_WIDTH)
    ) u_pre_ram (
        .i_clk  (i_clk),
        .i_we   (r_up_vld),
        .i_waddr(r_idx),
        .i_wdata(up_pre),
        .i_raddr(pre_raddr),
        .o_rdata(pre_rdata)
    );

    // Handshake terms.
    always_comb begin
        take       = (i_uword.act == A_TAKE);
        accept     = i_in_valid && take;
        o_in_stall = !take;
        out_busy   = r_out_valid && i_out_stall;
        res_load   = (i_uword.act == A_RESULT) && !out_busy;
    end

    // Span arithmetic and the fit test.
    always_comb begin
        w_ext       = SW'(r_w);
        span_end    = SW'(r_cnt) + w_ext;
        inrange_now = span_end < SW'(SHEET_WIDTH);
        pre_raddr   = AW'(span_end - SW'(1));
        raise_sum   = FW'(r_best) + FW'(r_h);
        fit         = raise_sum <= FW'(SHEET_HEIGHT);
        granted     = r_found && fit;
        bx_ext      = SW'(r_bx);
        best_ext    = FW'(r_best);
        col_we      = (i_uword.act == A_CLEAR) || (i_uword.act == A_RAISE);
        col_wdata   = (i_uword.act == A_RAISE) ? HW'(raise_sum) : '0;
    end

    // Forward pass: running maximum that restarts at each block of width w.
    always_comb begin
        up_pre = ((r_k == 8'd0) || (col_rdata > r_pre)) ? col_rdata : r_pre;
        k_inc  = (r_k == r_w - 8'd1) ? 8'd0 : r_k + 8'd1;
    end

    // Backward pass: running maximum to the block end, joined with the prefix
    // at the span's last column to give the span height.
    always_comb begin
        k_dec    = (r_k == 8'd0) ? r_w - 8'd1 : r_k - 8'd1;
        dn_suf   = ((k_dec == r_w - 8'd1) || (col_rdata > r_suf)) ? col_rdata : r_suf;
        span_top = (pre_rdata > dn_suf) ? pre_rdata : dn_suf;
        better   = r_inrange && (span_top < HW'(SHEET_HEIGHT))
                   && (!r_found || (span_top <= r_best));
    end

    // Column counter.
    always_comb begin
        case (i_uword.cnt_op)
            CNT_HOLD: n_cnt = r_cnt;
            CNT_ZERO: n_cnt = '0;
            CNT_TOP:  n_cnt = AW'(SHEET_WIDTH - 1);
            CNT_UP:   n_cnt = r_cnt + AW'(1);
            CNT_DOWN: n_cnt = r_cnt - AW'(1);
            CNT_BX:   n_cnt = r_bx;
            default:  n_cnt = r_cnt;
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt       <= '0;
            r_k         <= '0;
            r_found     <= 1'b0;
            r_up_vld    <= 1'b0;
            r_dn_vld    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_cnt    <= n_cnt;
            r_up_vld <= (i_uword.act == A_SCAN_UP);
            r_dn_vld <= (i_uword.act == A_SCAN_DOWN);
            if (accept) begin
                r_k     <= '0;
                r_found <= 1'b0;
            end else if (i_uword.act == A_ZERO) begin
                r_found <= 1'b1;
            end else if (r_up_vld) begin
                r_k <= k_inc;
            end else if (r_dn_vld) begin
                r_k <= k_dec;
                if (better) begin
                    r_found <= 1'b1;
                end
            end
            if (res_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_idx     <= r_cnt;
        r_inrange <= inrange_now;
        if (accept) begin
            r_kind <= i_kind;
            r_w    <= i_rect_width;
            r_h    <= i_rect_height;
        end
        if (r_up_vld) begin
            r_pre <= up_pre;
        end
        if (r_dn_vld) begin
            r_suf <= dn_suf;
            if (better) begin
                r_best <= span_top;
                r_bx   <= r_idx;
            end
        end
        if (i_uword.act == A_ZERO) begin
            r_best <= '0;
            r_bx   <= '0;
        end
        if (i_uword.act == A_DECIDE) begin
            r_end <= AW'(bx_ext + w_ext - SW'(1));
        end
        if (res_load) begin
            r_granted <= granted;
            r_pos_x   <= granted ? bx_ext[6:0] : 7'd0;
            r_pos_y   <= granted ? best_ext[7:0] : 8'd0;
        end
    end

    // Flags for the sequencer.
    always_comb begin
        o_status.accept   = accept;
        o_status.is_clear = r_kind;
        o_status.w_zero   = (r_w == 8'd0);
        o_status.too_wide = w_ext >= SW'(SHEET_WIDTH);
        o_status.cnt_last = (r_cnt == AW'(SHEET_WIDTH - 1));
        o_status.cnt_zero = (r_cnt == '0);
        o_status.no_write = !r_found || !fit || (r_w == 8'd0);
        o_status.cnt_end  = (r_cnt == r_end);
        o_status.out_busy = out_busy;
    end

    assign o_out_valid = r_out_valid;
    assign o_granted   = r_granted;
    assign o_pos_x     = r_pos_x;
    assign o_pos_y     = r_pos_y;

    `SRA_AST_HOLD(a_found_below, i_clk, i_rst_n, r_found, r_best < HW'(SHEET_HEIGHT), "chosen span height reached the sheet top")
    `SRA_AST_HOLD(a_raise_in_span, i_clk, i_rst_n, i_uword.act == A_RAISE, r_cnt <= r_end, "raise ran past the span")
    `SRA_AST_HOLD(a_phase_in_width, i_clk, i_rst_n, r_up_vld || r_dn_vld, r_k < r_w, "block phase out of range")

endmodule
